[design/lmwo_pkg.sv]
`timescale 1ns / 1ps

package lmwo_pkg;

  localparam int unsigned VAL_W   = 17;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned CFG_D_W = 32;

  localparam logic [31:0] DIV3_MUL   = 32'd87382;
  localparam int unsigned DIV3_SHIFT = 18;
  localparam logic [31:0] OUT_SCALE  = 32'd255;

  localparam logic [63:0] ONE_Q30     = 64'h0000_0000_4000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_A_W-1:0] REG_OSC_STEP = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_OSC_WAVE = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_LFO_STEP = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_LFO_WAVE = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_LFO_DEPTH = 3'd4;

  localparam logic [31:0] OSC_STEP_RST  = 32'd21474836;
  localparam logic [31:0] LFO_STEP_RST  = 32'd894784;
  localparam logic [15:0] LFO_DEPTH_RST = 16'd13107;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_RAMP   = 2'd1,
    WAVE_SQUARE = 2'd2
  } wave_e;

  typedef enum logic [3:0] {
    OP_IDX_LFO,
    OP_ROM_LFO,
    OP_SET_LFO,
    OP_MAG,
    OP_DELTA,
    OP_INC,
    OP_IDX_OSC,
    OP_ROM_K,
    OP_ROM_2K,
    OP_ROM_3K,
    OP_SUM3,
    OP_DIV3,
    OP_DIVFIX,
    OP_SIMPLE,
    OP_OUT_MUL,
    OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_OSC_NOT_SINE
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  localparam logic [STEP_W-1:0] STEP_SIMPLE  = 4'd13;
  localparam logic [STEP_W-1:0] STEP_OUT_MUL = 4'd14;

  function automatic ucode_t ucode(logic [STEP_W-1:0] step);
    ucode_t cw;
    cw = '{op: OP_FINISH, cond: COND_NONE, target: '0};
    case (step)
      4'd0:  cw = '{op: OP_IDX_LFO, cond: COND_NONE, target: '0};
      4'd1:  cw = '{op: OP_ROM_LFO, cond: COND_NONE, target: '0};
      4'd2:  cw = '{op: OP_SET_LFO, cond: COND_NONE, target: '0};
      4'd3:  cw = '{op: OP_MAG, cond: COND_NONE, target: '0};
      4'd4:  cw = '{op: OP_DELTA, cond: COND_NONE, target: '0};
      4'd5:  cw = '{op: OP_INC, cond: COND_NONE, target: '0};
      4'd6:  cw = '{op: OP_IDX_OSC, cond: COND_OSC_NOT_SINE, target: STEP_SIMPLE};
      4'd7:  cw = '{op: OP_ROM_K, cond: COND_NONE, target: '0};
      4'd8:  cw = '{op: OP_ROM_2K, cond: COND_NONE, target: '0};
      4'd9:  cw = '{op: OP_ROM_3K, cond: COND_NONE, target: '0};
      4'd10: cw = '{op: OP_SUM3, cond: COND_NONE, target: '0};
      4'd11: cw = '{op: OP_DIV3, cond: COND_NONE, target: '0};
      4'd12: cw = '{op: OP_DIVFIX, cond: COND_ALWAYS, target: STEP_OUT_MUL};
      4'd13: cw = '{op: OP_SIMPLE, cond: COND_NONE, target: '0};
      4'd14: cw = '{op: OP_OUT_MUL, cond: COND_NONE, target: '0};
      4'd15: cw = '{op: OP_FINISH, cond: COND_NONE, target: '0};
      default: cw = '{op: OP_FINISH, cond: COND_NONE, target: '0};
    endcase
    return cw;
  endfunction

  // sin(pi/2 * t), t in Q30 on [0, 1], result in Q15 (0 .. 32768)
  function automatic logic [VAL_W-1:0] quarter_sine(logic [63:0] t);
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] acc;
    logic [63:0] d;
    logic [63:0] v;
    y   = (HALF_PI_Q30 * t) >> 30;
    y2  = (y * y) >> 30;
    acc = ONE_Q30;
    d   = ((y2 * acc) >> 30) / 64'd110;
    acc = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    d   = ((y2 * acc) >> 30) / 64'd72;
    acc = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    d   = ((y2 * acc) >> 30) / 64'd42;
    acc = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    d   = ((y2 * acc) >> 30) / 64'd20;
    acc = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    d   = ((y2 * acc) >> 30) / 64'd6;
    acc = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    v   = (y * acc) >> 30;
    v   = (v + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return VAL_W'(v);
  endfunction

endpackage

[design/lmwo_sine_rom.sv]
`timescale 1ns / 1ps

module lmwo_sine_rom #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic [$clog2(DEPTH)-1:0]               addr_i,
  output logic signed [lmwo_pkg::VAL_W-1:0]      data_o
);

  logic signed [lmwo_pkg::VAL_W-1:0] rom_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam int unsigned X4   = 4 * i;
    localparam int unsigned QUAD = X4 / DEPTH;
    localparam int unsigned R    = X4 % DEPTH;
    localparam int unsigned NUM  = ((QUAD % 2) == 1) ? (DEPTH - R) : R;
    localparam logic [63:0] T    = (64'(NUM) << 30) / DEPTH;
    localparam logic signed [lmwo_pkg::VAL_W-1:0] V = lmwo_pkg::quarter_sine(T);
    assign rom_w[i] = (QUAD >= 2) ? -V : V;
  end

  always_ff @(posedge clk_i) begin
    data_o <= rom_w[addr_i];
  end

endmodule

[design/lfo_modulated_wavetable_oscillator.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[0] tick
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata[7:0] pwm_sample
// cfg       in   cfg_we_i (no wait)             cfg_addr_i index, cfg_wdata_i value
//
// A tick is accepted while the block is idle, then runs the microprogram on one shared 32x32
// multiplier and a registered sine ROM port: 15 steps for harmonic sine, 10 for saw,
// square or unused code. The three harmonic ROM reads and the divide by three set the
// sine length. A tick of 0 is taken and dropped.
// The next tick is taken while the previous sample still waits in the output register;
// the last step holds until that register is free. Reset is asynchronous, active low,
// and needs no clearing pass.

module lfo_modulated_wavetable_oscillator #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [0] tick
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [7:0] pwm_sample
  input  logic                              cfg_we_i,
  input  logic [lmwo_pkg::CFG_A_W-1:0]      cfg_addr_i,
  input  logic [lmwo_pkg::CFG_D_W-1:0]      cfg_wdata_i
);

  localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH);
  localparam logic [IW:0] DEPTH_X = (IW + 1)'(SINE_TABLE_DEPTH);
  localparam logic [31:0] DEPTH_W = 32'(SINE_TABLE_DEPTH);
  localparam int unsigned VW = lmwo_pkg::VAL_W;
  localparam int unsigned SW = lmwo_pkg::SUM_W;

  logic [31:0] osc_step_q;
  logic [1:0]  osc_wave_q;
  logic [31:0] lfo_step_q;
  logic [1:0]  lfo_wave_q;
  logic [15:0] lfo_depth_q;

  logic [31:0] osc_phase_q, lfo_phase_q;

  logic                          busy_q, busy_d;
  logic [lmwo_pkg::STEP_W-1:0]   step_q, step_d;
  lmwo_pkg::ucode_t              cw;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q;

  logic [63:0]           prod_q;
  logic [31:0]           mul_a, mul_b;
  logic                  mul_en;
  logic signed [VW-1:0]  lfo_q, s_q, s_simple;
  logic signed [SW-1:0]  sum_q;
  logic [31:0]           inc_q;
  logic [IW-1:0]         k_q, rom_addr, prod_idx, k2, k3;
  logic [IW:0]           k2_x, k3_x;
  logic signed [VW-1:0]  rom_data;
  logic signed [VW-1:0]  lfo_sel;
  logic [VW-1:0]         lfo_abs, div_q, s_bias;
  logic [SW-1:0]         sum_abs;
  logic [31:0]           delta;
  logic                  out_free, finish, jump;

  lmwo_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign cw = lmwo_pkg::ucode(step_q);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_step_q  <= lmwo_pkg::OSC_STEP_RST;
      osc_wave_q  <= lmwo_pkg::WAVE_SINE;
      lfo_step_q  <= lmwo_pkg::LFO_STEP_RST;
      lfo_wave_q  <= lmwo_pkg::WAVE_RAMP;
      lfo_depth_q <= lmwo_pkg::LFO_DEPTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lmwo_pkg::REG_OSC_STEP:  osc_step_q  <= cfg_wdata_i;
        lmwo_pkg::REG_OSC_WAVE:  osc_wave_q  <= cfg_wdata_i[1:0];
        lmwo_pkg::REG_LFO_STEP:  lfo_step_q  <= cfg_wdata_i;
        lmwo_pkg::REG_LFO_WAVE:  lfo_wave_q  <= cfg_wdata_i[1:0];
        lmwo_pkg::REG_LFO_DEPTH: lfo_depth_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // index arithmetic
  assign prod_idx = prod_q[32 +: IW];
  assign k2_x     = {k_q, 1'b0};
  assign k2       = (k2_x >= DEPTH_X) ? IW'(k2_x - DEPTH_X) : IW'(k2_x);
  assign k3_x     = {1'b0, k2} + {1'b0, k_q};
  assign k3       = (k3_x >= DEPTH_X) ? IW'(k3_x - DEPTH_X) : IW'(k3_x);

  assign lfo_abs  = lfo_q[VW-1] ? VW'(-lfo_q) : VW'(lfo_q);
  assign sum_abs  = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign delta    = prod_q[62:31];
  assign div_q    = prod_q[lmwo_pkg::DIV3_SHIFT +: VW];
  assign s_bias   = VW'(s_q) + VW'(32768);

  always_comb begin
    case (lfo_wave_q)
      lmwo_pkg::WAVE_SINE:   lfo_sel = rom_data;
      lmwo_pkg::WAVE_RAMP:   lfo_sel = $signed({1'b0, lfo_phase_q[31:16]}) - VW'(32768);
      lmwo_pkg::WAVE_SQUARE: lfo_sel = lfo_phase_q[31] ? VW'(32768) : -VW'(32768);
      default:               lfo_sel = '0;
    endcase
  end

  always_comb begin
    case (osc_wave_q)
      lmwo_pkg::WAVE_RAMP:   s_simple = $signed({1'b0, osc_phase_q[31:16]}) - VW'(32768);
      lmwo_pkg::WAVE_SQUARE: s_simple = osc_phase_q[31] ? VW'(32768) : -VW'(32768);
      default:               s_simple = '0;
    endcase
  end

  // operand and address selection
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    rom_addr = prod_idx;
    case (cw.op)
      lmwo_pkg::OP_IDX_LFO: begin
        mul_a = lfo_phase_q;
        mul_b = DEPTH_W;
      end
      lmwo_pkg::OP_MAG: begin
        mul_a = 32'(lfo_abs);
        mul_b = 32'(lfo_depth_q);
      end
      lmwo_pkg::OP_DELTA: begin
        mul_a = osc_step_q;
        mul_b = prod_q[31:0];
      end
      lmwo_pkg::OP_IDX_OSC: begin
        mul_a = osc_phase_q;
        mul_b = DEPTH_W;
      end
      lmwo_pkg::OP_ROM_2K: rom_addr = k2;
      lmwo_pkg::OP_ROM_3K: rom_addr = k3;
      lmwo_pkg::OP_DIV3: begin
        mul_a = 32'(sum_abs);
        mul_b = lmwo_pkg::DIV3_MUL;
      end
      lmwo_pkg::OP_OUT_MUL: begin
        mul_a = 32'(s_bias);
        mul_b = lmwo_pkg::OUT_SCALE;
      end
      default: ;
    endcase
  end

  assign mul_en = busy_q && (cw.op inside {lmwo_pkg::OP_IDX_LFO, lmwo_pkg::OP_MAG,
                                           lmwo_pkg::OP_DELTA, lmwo_pkg::OP_IDX_OSC,
                                           lmwo_pkg::OP_DIV3, lmwo_pkg::OP_OUT_MUL});

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= 64'(mul_a) * 64'(mul_b);
    end
    if (busy_q) begin
      case (cw.op)
        lmwo_pkg::OP_SET_LFO: lfo_q <= lfo_sel;
        lmwo_pkg::OP_INC:     inc_q <= lfo_q[VW-1] ? osc_step_q - delta : osc_step_q + delta;
        lmwo_pkg::OP_ROM_K: begin
          k_q   <= prod_idx;
          sum_q <= '0;
        end
        lmwo_pkg::OP_ROM_2K:  sum_q <= sum_q + SW'(rom_data);
        lmwo_pkg::OP_ROM_3K:  sum_q <= sum_q + SW'(rom_data);
        lmwo_pkg::OP_SUM3:    sum_q <= sum_q + SW'(rom_data);
        lmwo_pkg::OP_DIVFIX:  s_q   <= sum_q[SW-1] ? -$signed(div_q) : $signed(div_q);
        lmwo_pkg::OP_SIMPLE:  s_q   <= s_simple;
        default: ;
      endcase
    end
    if (finish) begin
      out_data_q <= (|prod_q[31:24]) ? 8'hFF : prod_q[23:16];
    end
  end

  // sequencer
  assign out_free      = !out_valid_q || m_axis_tready;
  assign finish        = busy_q && (cw.op == lmwo_pkg::OP_FINISH) && out_free;
  assign s_axis_tready = !busy_q;

  always_comb begin
    case (cw.cond)
      lmwo_pkg::COND_ALWAYS:       jump = 1'b1;
      lmwo_pkg::COND_OSC_NOT_SINE: jump = (osc_wave_q != lmwo_pkg::WAVE_SINE);
      default:                     jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      step_d = '0;
      if (s_axis_tvalid && s_axis_tdata[0]) begin
        busy_d = 1'b1;
      end
    end else if (cw.op == lmwo_pkg::OP_FINISH) begin
      if (out_free) begin
        busy_d = 1'b0;
        step_d = '0;
      end
    end else if (jump) begin
      step_d = cw.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      osc_phase_q <= '0;
      lfo_phase_q <= '0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (finish) begin
        osc_phase_q <= osc_phase_q + inc_q;
        lfo_phase_q <= lfo_phase_q + lfo_step_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
